// File: sv/frs_pkg.sv
// Shared widths, codes and helpers for the frame RMSD block.
`default_nettype none

package frs_pkg;

  localparam int unsigned MAX_ATOMS_DEF = 4096;
  localparam int unsigned NUM_ATOMS_W   = 13;
  localparam int unsigned NUM_ATOMS_RST = 4096;
  localparam int unsigned COORD_W       = 24;
  localparam int unsigned DIFF_W        = COORD_W + 1;
  localparam int unsigned SQ_W          = 50;
  localparam int unsigned INDEX_W       = 12;
  localparam int unsigned RMSD_W        = 25;
  localparam int unsigned SUM_W         = 64;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // magnitude of a - b, always fits DIFF_W bits unsigned
  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

`default_nettype wire

// File: sv/frs_ref_mem.sv
// Reference atom store: one write port, one registered read port.
`default_nettype none

module frs_ref_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 72
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/frs_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module frs_div #(
  parameter int unsigned DVD_W = 64,
  parameter int unsigned DVS_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    quo_d   = {quo_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: sv/frs_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module frs_isqrt #(
  parameter int unsigned RAD_W = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [RAD_W-1:0]   radicand_i,
  output logic                    done_o,
  output logic      [RAD_W/2-1:0] root_o
);

  localparam int unsigned HW    = RAD_W / 2;
  localparam int unsigned CNT_W = $clog2(HW + 1);

  logic [RAD_W-1:0] rad_q;
  logic [HW:0]      rem_q, rem_d;
  logic [HW-1:0]    root_q, root_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [HW+2:0]    shifted;
  logic [HW+2:0]    trial;
  logic [HW+2:0]    diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = shifted >= trial;
    diff    = shifted - trial;
    rem_d   = ge ? diff[HW:0] : shifted[HW:0];
    root_d  = {root_q[HW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(HW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: sv/frame_rmsd_to_reference.sv
// Top level: per-atom squared distance and per-frame RMSD against a stored reference.
// Load words: one per cycle in idle; each writes one reference atom into the store.
// Sample words: taken one at a time (read, diff, square, sum, hand-off); result follows.
// Last sample of a frame: a further divide by the atom count and a square root follow.
// The result register frees the input side while a result waits to be taken.
// Reset (async, low) clears positions, frame sum and control; atom count returns to 4096.
`default_nettype none

module frame_rmsd_to_reference #(
  parameter int unsigned MAX_ATOMS = frs_pkg::MAX_ATOMS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write channel (atom count)
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic        [frs_pkg::NUM_ATOMS_W-1:0] cfg_data_i,
  // input words
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                cmd_i,
  input  wire logic signed [frs_pkg::COORD_W-1:0]  coord_x_i,
  input  wire logic signed [frs_pkg::COORD_W-1:0]  coord_y_i,
  input  wire logic signed [frs_pkg::COORD_W-1:0]  coord_z_i,
  // result words
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [frs_pkg::INDEX_W-1:0]  atom_index_o,
  output logic             [frs_pkg::SQ_W-1:0]     sq_dist_o,
  output logic             [frs_pkg::RMSD_W-1:0]   rmsd_o,
  output logic                                     frame_end_o
);

  import frs_pkg::*;

  localparam int unsigned AW     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CW     = $clog2(MAX_ATOMS + 1);
  localparam int unsigned WORD_W = 3 * COORD_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIFF = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_SUM  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [NUM_ATOMS_W-1:0] num_atoms_q;

  // positions and frame accumulator
  logic [AW-1:0]    load_pos_q, sample_pos_q;
  logic [SUM_W-1:0] frame_sum_q;

  // captured sample
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [AW-1:0]             idx_q;
  logic                      last_q;

  // arithmetic pipeline registers
  logic [DIFF_W-1:0] adx_q, ady_q, adz_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [SQ_W-1:0]   dist_q;
  logic [RMSD_W-1:0] rmsd_res_q;

  // result register
  logic               out_valid_q;
  logic [INDEX_W-1:0] atom_index_q;
  logic [SQ_W-1:0]    sq_dist_q;
  logic [RMSD_W-1:0]  rmsd_q;
  logic               frame_end_q;

  // effective atom count and clamped positions
  logic [CW-1:0] n_eff, n_m1;
  logic          s_last, l_last;
  logic [AW-1:0] s_addr, l_addr;

  // handshakes and memory port
  logic              in_acc;
  logic              mem_we, mem_re;
  logic [WORD_W-1:0] mem_rdata;
  logic              out_load;

  // arithmetic
  logic [SQ_W-1:0]  dist_sum;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  // tail units
  logic              div_start, div_done;
  logic [SUM_W-1:0]  quotient;
  logic              sqrt_start, sqrt_done;
  logic [SUM_W/2-1:0] root;

  // Clamp the count: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    if (num_atoms_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(num_atoms_q) > MAX_ATOMS) begin
      n_eff = CW'(MAX_ATOMS);
    end else begin
      n_eff = CW'(num_atoms_q);
    end
    n_m1 = n_eff - CW'(1);
  end

  // A position at or past the last atom counts as the last atom; this also
  // covers a count lowered in the middle of a frame.
  always_comb begin
    s_last = CW'(sample_pos_q) >= n_m1;
    l_last = CW'(load_pos_q) >= n_m1;
    s_addr = s_last ? AW'(n_m1) : sample_pos_q;
    l_addr = l_last ? AW'(n_m1) : load_pos_q;
  end

  // Loads are taken every cycle in idle; a sample holds the input side
  // until its result has moved into the output register.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign mem_we      = in_acc && (cmd_i == CMD_LOAD);
  assign mem_re      = in_acc && (cmd_i == CMD_SAMPLE);
  assign cfg_ready_o = 1'b1;

  frs_ref_mem #(
    .DEPTH  (MAX_ATOMS),
    .ADDR_W (AW),
    .DATA_W (WORD_W)
  ) u_ref_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (l_addr),
    .wdata_i ({coord_x_i, coord_y_i, coord_z_i}),
    .re_i    (mem_re),
    .raddr_i (s_addr),
    .rdata_o (mem_rdata)
  );

  // Three squares, then a saturating add into the frame sum.
  always_comb begin
    dist_sum = sqx_q + sqy_q + sqz_q;
    sum_wide = {1'b0, frame_sum_q} + (SUM_W + 1)'(dist_sum);
    sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  end

  assign div_start  = (state_q == ST_SUM) && last_q;
  assign sqrt_start = (state_q == ST_DIV) && div_done;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  frs_div #(
    .DVD_W (SUM_W),
    .DVS_W (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_sat),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  frs_isqrt #(
    .RAD_W (SUM_W)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (quotient),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (mem_re) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = last_q ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_atoms_q  <= NUM_ATOMS_W'(NUM_ATOMS_RST);
      load_pos_q   <= '0;
      sample_pos_q <= '0;
      frame_sum_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_atoms_q <= cfg_data_i;
      end
      // advance or wrap the load position
      if (mem_we) begin
        load_pos_q <= l_last ? '0 : load_pos_q + AW'(1);
      end
      // advance or wrap the sample position at acceptance
      if (mem_re) begin
        sample_pos_q <= s_last ? '0 : sample_pos_q + AW'(1);
      end
      // accumulate, or clear on the last atom of the frame
      if (state_q == ST_SUM) begin
        frame_sum_q <= last_q ? '0 : sum_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      cx_q   <= coord_x_i;
      cy_q   <= coord_y_i;
      cz_q   <= coord_z_i;
      idx_q  <= s_addr;
      last_q <= s_last;
    end
    if (state_q == ST_DIFF) begin
      adx_q <= abs_diff(cx_q, $signed(mem_rdata[3*COORD_W-1 -: COORD_W]));
      ady_q <= abs_diff(cy_q, $signed(mem_rdata[2*COORD_W-1 -: COORD_W]));
      adz_q <= abs_diff(cz_q, $signed(mem_rdata[COORD_W-1:0]));
    end
    if (state_q == ST_MUL) begin
      sqx_q <= SQ_W'(adx_q) * SQ_W'(adx_q);
      sqy_q <= SQ_W'(ady_q) * SQ_W'(ady_q);
      sqz_q <= SQ_W'(adz_q) * SQ_W'(adz_q);
    end
    if (state_q == ST_SUM) begin
      dist_q <= dist_sum;
    end
    if (sqrt_done) begin
      rmsd_res_q <= root[RMSD_W-1:0];
    end
    if (out_load) begin
      atom_index_q <= INDEX_W'(idx_q);
      sq_dist_q    <= dist_q;
      rmsd_q       <= last_q ? rmsd_res_q : '0;
      frame_end_q  <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign atom_index_o = atom_index_q;
  assign sq_dist_o    = sq_dist_q;
  assign rmsd_o       = rmsd_q;
  assign frame_end_o  = frame_end_q;

`ifndef SYNTHESIS
  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("reference store written and read in the same cycle");

  a_rmsd_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_end_o) |-> (rmsd_o == '0))
    else $error("rmsd non-zero on a word that does not end a frame");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SUM) && last_q) |=> (frame_sum_q == '0))
    else $error("frame sum not cleared after the last atom");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  a_sqrt_done_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_SQRT))
    else $error("square root finished outside its wait state");
`endif

endmodule

`default_nettype wire
